FILE: rtl/rng_pkg.sv
`timescale 1ns / 1ps
package rng_pkg;
  localparam int unsigned SampleBits = 24;
  localparam int unsigned Window     = 64;
  localparam int unsigned WinAw      = 6;
  localparam int unsigned SqBits     = 2 * (SampleBits - 1);
  localparam int unsigned SumBits    = SqBits + WinAw;
  localparam int unsigned CfgAw      = 2;
  localparam int unsigned CfgDw      = 23;

  localparam logic [CfgAw-1:0] RegThreshold = 2'd0;
  localparam logic [CfgAw-1:0] RegAttack    = 2'd1;
  localparam logic [CfgAw-1:0] RegRelease   = 2'd2;

  localparam logic [16:0] UnityGain = 17'd65536;
  localparam logic [20:0] HoldMax   = 21'h1FFFFF;

  typedef enum logic [1:0] {
    ModeOpen    = 2'd0,
    ModeClosing = 2'd1,
    ModeClosed  = 2'd2,
    ModeOpening = 2'd3
  } gate_mode_e;

  typedef enum logic [2:0] {
    StIdle, StRead, StSq, StThr, StGate, StDiv, StMul, StOut
  } seq_state_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] audio_sample;
    logic signed [SampleBits-1:0] detect_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] gated_sample;
    logic [16:0]                  gain_value;
    gate_mode_e                   gate_mode;
  } out_item_t;
endpackage

FILE: rtl/rms_noise_gate.sv
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// in       in   in_valid_i/ready_o   rng_pkg::in_item_t
// out      out  out_valid_o/ready_i  rng_pkg::out_item_t
// cfg      in   cfg_we_i             cfg_idx_i, cfg_wdata_i
// One shift-add multiplier, one bit per cycle except while the last multiply step
// is held: a load step, the detector square, the threshold square, a gate step and
// the gated product. in_ready_o returns in the same cycle that the result shows, so
// a new sample is taken only once the last one is done. A ramp start of non-zero
// length adds a restoring divide. Window memory is a 64-entry RAM cleared by a
// pass over every entry after reset, during which in_ready_o is low. A result still
// waiting in the output register holds the last multiply step.
module rms_noise_gate (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rng_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rng_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [rng_pkg::CfgAw-1:0]    cfg_idx_i,
  input  logic [rng_pkg::CfgDw-1:0]    cfg_wdata_i
);
  localparam int unsigned SB = rng_pkg::SampleBits;
  localparam int unsigned MW = 64;

  logic [22:0] thr_q;
  logic [19:0] att_q, rel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 23'd8389;
      att_q <= 20'd480;
      rel_q <= 20'd4800;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rng_pkg::RegThreshold: thr_q <= cfg_wdata_i;
        rng_pkg::RegAttack:    att_q <= cfg_wdata_i[19:0];
        rng_pkg::RegRelease:   rel_q <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  logic [rng_pkg::SqBits-1:0] win_mem [rng_pkg::Window];
  logic [rng_pkg::SqBits-1:0] win_rd_q;
  logic                       win_we;
  logic [rng_pkg::WinAw-1:0]  win_wa;
  logic [rng_pkg::SqBits-1:0] win_wd;

  rng_pkg::seq_state_e st_q, st_d;
  rng_pkg::gate_mode_e mode_q, mode_d;
  logic                        clr_q;
  logic [rng_pkg::WinAw-1:0]   pos_q, pos_d;
  logic [rng_pkg::SumBits-1:0] sum_q, sum_d;
  logic [20:0] hold_q, hold_d;
  logic [16:0] gain_q, gain_d;
  logic [19:0] rleft_q, rleft_d;
  logic [17:0] rstep_q, rstep_d;
  rng_pkg::in_item_t in_q;
  logic [rng_pkg::SqBits-1:0] sq_q, sq_d;
  logic        out_v_q, out_v_d;
  rng_pkg::out_item_t out_q, out_d;
  // shared shift-add multiplier
  logic [MW-1:0] acc_q, acc_d, mcand_q, mcand_d;
  logic [40:0]   mplier_q, mplier_d;
  logic [5:0]    cnt_q, cnt_d;
  // divider
  logic [19:0]   dsor_q, dsor_d;
  logic [16:0]   quo_q, quo_d;
  logic [20:0]   rem_q, rem_d;
  logic          dn_q, dn_d;

  logic [SB-1:0] det_mag;
  logic [rng_pkg::SumBits-1:0] new_sum;
  logic [rng_pkg::SumBits:0]   limit;
  logic above, below;
  logic start_ramp, ramp_up;
  logic [19:0] ramp_len;
  logic [20:0] hold_inc;
  logic [20:0] rem_sh;
  logic [17:0] gsum;
  logic        mul_hold;

  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[win_wa] <= win_wd;
    win_rd_q <= win_mem[pos_q];
  end

  always_comb begin
    if (in_q.detect_sample == {1'b1, {(SB-1){1'b0}}}) det_mag = {1'b0, {(SB-1){1'b1}}};
    else if (in_q.detect_sample[SB-1]) det_mag = SB'(-in_q.detect_sample);
    else det_mag = in_q.detect_sample;
  end

  assign new_sum = sum_q - rng_pkg::SumBits'(win_rd_q) + rng_pkg::SumBits'(sq_q);
  assign limit   = {acc_q[rng_pkg::SumBits-rng_pkg::WinAw:0], {rng_pkg::WinAw{1'b0}}};
  assign above   = {1'b0, sum_q} > limit;
  assign below   = {1'b0, sum_q} < limit;
  assign hold_inc = (hold_q < rng_pkg::HoldMax) ? hold_q + 21'd1 : rng_pkg::HoldMax;
  assign mul_hold = (st_q == rng_pkg::StMul) && (cnt_q == 6'd1) && out_v_q && !out_ready_i;

  always_comb begin
    st_d = st_q; mode_d = mode_q; pos_d = pos_q; sum_d = sum_q;
    hold_d = hold_q; gain_d = gain_q; rleft_d = rleft_q; rstep_d = rstep_q;
    sq_d = sq_q; out_v_d = out_v_q; out_d = out_q;
    acc_d = acc_q; mcand_d = mcand_q; mplier_d = mplier_q; cnt_d = cnt_q;
    dsor_d = dsor_q; quo_d = quo_q; rem_d = rem_q; dn_d = dn_q;
    win_we = 1'b0; win_wa = pos_q; win_wd = sq_q;
    start_ramp = 1'b0; ramp_up = 1'b0; ramp_len = '0; gsum = '0;
    rem_sh = {rem_q[19:0], 1'b0};
    in_ready_o = 1'b0;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    if (clr_q) begin
      win_we = 1'b1; win_wd = '0;
    end else begin
      case (st_q)
        rng_pkg::StIdle: begin
          in_ready_o = 1'b1;
          if (in_valid_i) st_d = rng_pkg::StRead;
        end
        rng_pkg::StRead: begin
          acc_d = '0; mcand_d = MW'(det_mag); mplier_d = 41'(det_mag);
          cnt_d = 6'(SB); st_d = rng_pkg::StSq;
        end
        rng_pkg::StSq, rng_pkg::StThr, rng_pkg::StMul: begin
          if (!mul_hold) begin
            if (mplier_q[0]) acc_d = acc_q + mcand_q;
            mcand_d = {mcand_q[MW-2:0], 1'b0};
            mplier_d = {1'b0, mplier_q[40:1]};
            cnt_d = cnt_q - 6'd1;
            if (cnt_q == 6'd1) begin
              if (st_q == rng_pkg::StSq) begin
                sq_d = acc_d[rng_pkg::SqBits-1:0];
                acc_d = '0; mcand_d = MW'(thr_q); mplier_d = 41'(thr_q);
                cnt_d = 6'd23; st_d = rng_pkg::StThr;
              end else if (st_q == rng_pkg::StThr) begin
                win_we = 1'b1;
                sum_d = new_sum;
                pos_d = pos_q + 1'b1;
                st_d = rng_pkg::StGate;
              end else begin
                out_d.gated_sample = acc_d[SB+15:16];
                out_d.gain_value = gain_q;
                out_d.gate_mode = mode_q;
                out_v_d = 1'b1;
                st_d = rng_pkg::StIdle;
              end
            end
          end
        end
        rng_pkg::StGate: begin
          case (mode_q)
            rng_pkg::ModeOpen: begin
              hold_d = '0; gain_d = rng_pkg::UnityGain; rleft_d = '0;
              if (below) begin
                mode_d = rng_pkg::ModeClosing; start_ramp = 1'b1; ramp_len = rel_q;
              end
            end
            rng_pkg::ModeClosing: begin
              hold_d = hold_inc;
              if (below && hold_inc > 21'(rel_q)) mode_d = rng_pkg::ModeClosed;
              else if (above) mode_d = rng_pkg::ModeOpen;
            end
            rng_pkg::ModeClosed: begin
              hold_d = '0; gain_d = '0; rleft_d = '0;
              if (above) begin
                mode_d = rng_pkg::ModeOpening; start_ramp = 1'b1;
                ramp_up = 1'b1; ramp_len = att_q;
              end
            end
            default: begin
              hold_d = hold_inc;
              if (above && hold_inc > 21'(att_q)) mode_d = rng_pkg::ModeOpen;
              else if (below) mode_d = rng_pkg::ModeClosed;
            end
          endcase
          st_d = rng_pkg::StMul;
          if (start_ramp) begin
            if (ramp_len == '0) begin
              gain_d = ramp_up ? rng_pkg::UnityGain : '0;
              rleft_d = '0; rstep_d = '0;
            end else begin
              rleft_d = ramp_len; dsor_d = ramp_len; dn_d = !ramp_up;
              rem_d = '0; quo_d = '0; cnt_d = 6'd17; st_d = rng_pkg::StDiv;
            end
          end
        end
        rng_pkg::StDiv: begin
          // restoring divide of 65536 by length, one quotient bit a cycle
          rem_sh[0] = (cnt_q == 6'd17);
          if (rem_sh >= 21'(dsor_q)) begin
            rem_d = rem_sh - 21'(dsor_q); quo_d = {quo_q[15:0], 1'b1};
          end else begin
            rem_d = rem_sh; quo_d = {quo_q[15:0], 1'b0};
          end
          cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            rstep_d = {dn_q, quo_d};
            st_d = rng_pkg::StMul;
          end
        end
        default: st_d = rng_pkg::StIdle;
      endcase
      if (st_q != rng_pkg::StMul && st_d == rng_pkg::StMul) begin
        if (rleft_d != '0) begin
          rleft_d = rleft_d - 20'd1;
          gsum = {1'b0, gain_d} + {1'b0, rstep_d[16:0]};
          if (rleft_d == '0) gain_d = rstep_d[17] ? 17'd0 : rng_pkg::UnityGain;
          else if (rstep_d[17]) gain_d = (gain_d > rstep_d[16:0]) ? gain_d - rstep_d[16:0] : '0;
          else gain_d = (gsum < 18'(rng_pkg::UnityGain)) ? gsum[16:0] : rng_pkg::UnityGain;
        end
        acc_d = '0;
        mcand_d = MW'(signed'(in_q.audio_sample));
        mplier_d = 41'(gain_d);
        cnt_d = 6'd17;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rng_pkg::StIdle; mode_q <= rng_pkg::ModeOpen; clr_q <= 1'b1;
      pos_q <= '0; sum_q <= '0; hold_q <= '0; gain_q <= '0;
      rleft_q <= '0; rstep_q <= '0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; mode_q <= mode_d; sum_q <= sum_d;
      hold_q <= hold_d; gain_q <= gain_d; rleft_q <= rleft_d; rstep_q <= rstep_d;
      out_v_q <= out_v_d;
      if (clr_q) begin
        pos_q <= pos_q + 1'b1;
        if (pos_q == rng_pkg::WinAw'(rng_pkg::Window - 1)) clr_q <= 1'b0;
      end else pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    sq_q <= sq_d; out_q <= out_d;
    acc_q <= acc_d; mcand_q <= mcand_d; mplier_q <= mplier_d; cnt_q <= cnt_d;
    dsor_q <= dsor_d; quo_q <= quo_d; rem_q <= rem_d; dn_q <= dn_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != rng_pkg::StIdle || clr_q) |-> !in_ready_o) else $error("ready while busy");
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= rng_pkg::UnityGain) else $error("gain above unity");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && $stable(out_q)))
    else $error("result dropped or changed while waiting");
endmodule
